// ----- hdl/keyed_quantity_record_table_macros.svh -----
// Assertion macros for the keyed quantity record table.
// Used by the datapath; needs nothing else.
`ifndef KEYED_QUANTITY_RECORD_TABLE_MACROS_SVH
`define KEYED_QUANTITY_RECORD_TABLE_MACROS_SVH

// property must hold at every edge outside reset
`define KQRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define KQRT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/kqrt_pkg.sv -----
// Shared types and constants of the keyed quantity record table.
// No dependencies.
package kqrt_pkg;

    localparam int KEY_W = 17;
    localparam int OP_W  = 3;
    localparam int ST_W  = 3;

    localparam logic [KEY_W-1:0] KEY_LOW   = 17'd10000;
    localparam logic [KEY_W-1:0] KEY_HIGH  = 17'd99999;
    localparam logic [32:0]      QTY_LIMIT = 33'd9999;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_REDUCE = 3'd4;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd5;
    localparam logic [OP_W-1:0] OP_SHIP   = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP       = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_FULFILLED = 3'd4;
    localparam logic [ST_W-1:0] ST_ZERO      = 3'd5;
    localparam logic [ST_W-1:0] ST_BAD_AMT   = 3'd6;
    localparam logic [ST_W-1:0] ST_NOTHING   = 3'd7;

    typedef enum logic [1:0] {WA_IDX, WA_ROW, WA_CNT} wa_sel_t;
    typedef enum logic [1:0] {WD_NEW, WD_HELD, WD_RD} wd_sel_t;
    typedef enum logic [1:0] {OS_NONE, OS_REC, OS_PEND} os_sel_t;

    // controller to datapath
    typedef struct packed {
        logic            capture;
        logic            idx_clr;
        logic            idx_inc;
        logic            idx_from_row;
        logic            rd_en;
        logic            rd_next;
        logic            wr_en;
        wa_sel_t         wa_sel;
        wd_sel_t         wd_sel;
        logic            hold_ld;
        logic            hold_new;
        logic            have_upd;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            pass_clr;
        logic            pass_inc;
        logic            pend_ld;
        logic            pend_clr;
        logic            out_ld;
        os_sel_t         out_src;
        logic            out_dec;
        logic            out_last;
        logic [ST_W-1:0] st;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            hit;
        logic            ship_eq;
        logic            idx_end;
        logic            idx1_end;
        logic            full;
        logic            range_bad;
        logic            add_full;
        logic            add_bad;
        logic            red_zero;
        logic            red_bad;
        logic            swap;
        logic            out_free;
        logic            pend_vld;
        logic            pass_end;
    } sts_t;

endpackage

// ----- hdl/kqrt_if.sv -----
// Channel interfaces of the keyed quantity record table.
// Depends on kqrt_pkg for field widths.
interface kqrt_req_if #(parameter int QTY_BITS = 14);
    logic                          valid;
    logic                          ready;
    logic [kqrt_pkg::OP_W-1:0]     opcode;
    logic [kqrt_pkg::KEY_W-1:0]    item_key;
    logic [QTY_BITS-1:0]           have_init;
    logic [QTY_BITS-1:0]           need_init;
    logic [QTY_BITS-1:0]           amount;

    modport source (output valid, opcode, item_key, have_init, need_init, amount,
                    input ready);
    modport sink   (input valid, opcode, item_key, have_init, need_init, amount,
                    output ready);
endinterface

interface kqrt_rsp_if #(parameter int QTY_BITS = 14, parameter int ROW_W = 6,
                        parameter int CNT_W = 7);
    logic                       valid;
    logic                       ready;
    logic [kqrt_pkg::ST_W-1:0]  status;
    logic [ROW_W-1:0]           row;
    logic [kqrt_pkg::KEY_W-1:0] rec_key;
    logic [QTY_BITS-1:0]        rec_have;
    logic [QTY_BITS-1:0]        rec_need;
    logic [CNT_W-1:0]           entries;
    logic                       last;

    modport source (output valid, status, row, rec_key, rec_have, rec_need, entries, last,
                    input ready);
    modport sink   (input valid, status, row, rec_key, rec_have, rec_need, entries, last,
                    output ready);
endinterface

// ----- hdl/kqrt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kqrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hdl/kqrt_dp.sv -----
// Datapath: record store, count, index, held record, pending ship beat, result register.
// Depends on kqrt_pkg, kqrt_ram and the assertion macro header.
`include "keyed_quantity_record_table_macros.svh"

module kqrt_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int QTY_BITS    = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kqrt_pkg::cmd_t                      cmd,
    output kqrt_pkg::sts_t                      sts,
    input  logic [kqrt_pkg::OP_W-1:0]           opcode,
    input  logic [kqrt_pkg::KEY_W-1:0]          item_key,
    input  logic [QTY_BITS-1:0]                 have_init,
    input  logic [QTY_BITS-1:0]                 need_init,
    input  logic [QTY_BITS-1:0]                 amount,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [kqrt_pkg::ST_W-1:0]           status,
    output logic [$clog2(TABLE_DEPTH)-1:0]      row,
    output logic [kqrt_pkg::KEY_W-1:0]          rec_key,
    output logic [QTY_BITS-1:0]                 rec_have,
    output logic [QTY_BITS-1:0]                 rec_need,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    entries,
    output logic                                last
);
    localparam int ROW_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REC_W = kqrt_pkg::KEY_W + 2 * QTY_BITS;

    // captured command
    logic [kqrt_pkg::OP_W-1:0]  op_reg;
    logic [kqrt_pkg::KEY_W-1:0] key_reg;
    logic [QTY_BITS-1:0]        hi_reg;
    logic [QTY_BITS-1:0]        ni_reg;
    logic [QTY_BITS-1:0]        amt_reg;

    // control counters
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pass_reg;

    // held record
    logic [kqrt_pkg::KEY_W-1:0] held_key_reg;
    logic [QTY_BITS-1:0]        held_have_reg;
    logic [QTY_BITS-1:0]        held_need_reg;
    logic [ROW_W-1:0]           row_reg;

    // pending ship beat
    logic                       pend_vld_reg;
    logic [ROW_W-1:0]           pend_row_reg;
    logic [kqrt_pkg::KEY_W-1:0] pend_key_reg;
    logic [QTY_BITS-1:0]        pend_have_reg;
    logic [QTY_BITS-1:0]        pend_need_reg;
    logic [CNT_W-1:0]           pend_cnt_reg;

    // result register
    logic                       out_vld_reg;
    logic [kqrt_pkg::ST_W-1:0]  out_st_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [kqrt_pkg::KEY_W-1:0] out_key_reg;
    logic [QTY_BITS-1:0]        out_have_reg;
    logic [QTY_BITS-1:0]        out_need_reg;
    logic [CNT_W-1:0]           out_cnt_reg;
    logic                       out_last_reg;

    // memory signals
    logic [ROW_W-1:0]           rd_addr;
    logic [ROW_W-1:0]           wr_addr;
    logic [REC_W-1:0]           wr_data;
    logic [REC_W-1:0]           rd_data;
    logic [kqrt_pkg::KEY_W-1:0] rd_key;
    logic [QTY_BITS-1:0]        rd_have;
    logic [QTY_BITS-1:0]        rd_need;

    logic [CNT_W-1:0]           idx_plus;
    logic [QTY_BITS-1:0]        gap;
    logic signed [QTY_BITS:0]   sf_held;
    logic signed [QTY_BITS:0]   sf_rd;
    logic [CNT_W-1:0]           cnt_less;

    assign rd_key   = rd_data[REC_W-1 -: kqrt_pkg::KEY_W];
    assign rd_have  = rd_data[2*QTY_BITS-1 -: QTY_BITS];
    assign rd_need  = rd_data[QTY_BITS-1:0];
    assign idx_plus = idx_reg + CNT_W'(1);
    assign gap      = held_need_reg - held_have_reg;
    assign sf_held  = $signed({1'b0, held_need_reg}) - $signed({1'b0, held_have_reg});
    assign sf_rd    = $signed({1'b0, rd_need}) - $signed({1'b0, rd_have});
    assign cnt_less = cnt_reg - CNT_W'(1);

    // memory addressing
    assign rd_addr = cmd.rd_next ? idx_plus[ROW_W-1:0] : idx_reg[ROW_W-1:0];

    always_comb
    begin
        case (cmd.wa_sel)
            kqrt_pkg::WA_IDX: wr_addr = idx_reg[ROW_W-1:0];
            kqrt_pkg::WA_ROW: wr_addr = row_reg;
            kqrt_pkg::WA_CNT: wr_addr = cnt_reg[ROW_W-1:0];
            default:          wr_addr = idx_reg[ROW_W-1:0];
        endcase
        case (cmd.wd_sel)
            kqrt_pkg::WD_NEW:  wr_data = {key_reg, hi_reg, ni_reg};
            kqrt_pkg::WD_HELD: wr_data = {held_key_reg, held_have_reg, held_need_reg};
            kqrt_pkg::WD_RD:   wr_data = rd_data;
            default:           wr_data = rd_data;
        endcase
    end

    kqrt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // status toward the controller
    always_comb
    begin
        sts.opcode    = op_reg;
        sts.hit       = (rd_key == key_reg);
        sts.ship_eq   = (rd_have == rd_need);
        sts.idx_end   = (idx_reg == cnt_reg);
        sts.idx1_end  = ((CNT_W+1)'(idx_reg) + (CNT_W+1)'(1)) >= (CNT_W+1)'(cnt_reg);
        sts.full      = (cnt_reg == CNT_W'(TABLE_DEPTH));
        sts.range_bad = (key_reg < kqrt_pkg::KEY_LOW) || (key_reg > kqrt_pkg::KEY_HIGH)
                        || (33'(hi_reg) > kqrt_pkg::QTY_LIMIT)
                        || (33'(ni_reg) > kqrt_pkg::QTY_LIMIT);
        sts.add_full  = (held_have_reg >= held_need_reg);
        sts.add_bad   = (amt_reg == '0) || (amt_reg > gap);
        sts.red_zero  = (held_have_reg == '0);
        sts.red_bad   = (amt_reg == '0) || (amt_reg > held_have_reg);
        sts.swap      = (sf_held < sf_rd);
        sts.out_free  = !out_vld_reg || rsp_ready;
        sts.pend_vld  = pend_vld_reg;
        sts.pass_end  = (pass_reg == cnt_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            idx_reg      <= '0;
            pass_reg     <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_less;
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_from_row)
            begin
                idx_reg <= CNT_W'(row_reg);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end

            if (cmd.pass_clr)
            begin
                pass_reg <= '0;
            end
            else if (cmd.pass_inc)
            begin
                pass_reg <= pass_reg + CNT_W'(1);
            end

            if (cmd.pend_ld)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.pend_clr)
            begin
                pend_vld_reg <= 1'b0;
            end

            if (cmd.out_ld)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            key_reg <= item_key;
            hi_reg  <= have_init;
            ni_reg  <= need_init;
            amt_reg <= amount;
        end

        if (cmd.hold_ld)
        begin
            held_key_reg  <= rd_key;
            held_have_reg <= rd_have;
            held_need_reg <= rd_need;
            row_reg       <= idx_reg[ROW_W-1:0];
        end
        else if (cmd.hold_new)
        begin
            held_key_reg  <= key_reg;
            held_have_reg <= hi_reg;
            held_need_reg <= ni_reg;
            row_reg       <= cnt_reg[ROW_W-1:0];
        end
        else if (cmd.have_upd)
        begin
            if (op_reg == kqrt_pkg::OP_ADD)
            begin
                held_have_reg <= held_have_reg + amt_reg;
            end
            else
            begin
                held_have_reg <= held_have_reg - amt_reg;
            end
        end

        if (cmd.pend_ld)
        begin
            pend_row_reg  <= row_reg;
            pend_key_reg  <= held_key_reg;
            pend_have_reg <= held_have_reg;
            pend_need_reg <= held_need_reg;
            pend_cnt_reg  <= cnt_less;
        end

        if (cmd.out_ld)
        begin
            out_st_reg <= cmd.st;
            case (cmd.out_src)
                kqrt_pkg::OS_REC:
                begin
                    out_row_reg  <= row_reg;
                    out_key_reg  <= held_key_reg;
                    out_have_reg <= held_have_reg;
                    out_need_reg <= held_need_reg;
                    out_cnt_reg  <= cmd.out_dec ? cnt_less : cnt_reg;
                    out_last_reg <= 1'b1;
                end
                kqrt_pkg::OS_PEND:
                begin
                    out_row_reg  <= pend_row_reg;
                    out_key_reg  <= pend_key_reg;
                    out_have_reg <= pend_have_reg;
                    out_need_reg <= pend_need_reg;
                    out_cnt_reg  <= pend_cnt_reg;
                    out_last_reg <= cmd.out_last;
                end
                default:
                begin
                    out_row_reg  <= '0;
                    out_key_reg  <= '0;
                    out_have_reg <= '0;
                    out_need_reg <= '0;
                    out_cnt_reg  <= cnt_reg;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign rsp_valid = out_vld_reg;
    assign status    = out_st_reg;
    assign row       = out_row_reg;
    assign rec_key   = out_key_reg;
    assign rec_have  = out_have_reg;
    assign rec_need  = out_need_reg;
    assign entries   = out_cnt_reg;
    assign last      = out_last_reg;

    // checks
    `KQRT_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > CNT_W'(TABLE_DEPTH), "count above depth")
    `KQRT_NEVER(a_idx_bound, clk, rst_n, idx_reg > cnt_reg, "index past count")
    `KQRT_NEVER(a_out_overrun, clk, rst_n, cmd.out_ld && out_vld_reg && !rsp_ready,
                "result overwritten before taken")
    `KQRT_NEVER(a_insert_full, clk, rst_n, cmd.cnt_inc && (cnt_reg == CNT_W'(TABLE_DEPTH)),
                "insert into full table")
    `KQRT_ASSERT(a_pend_ship, clk, rst_n, pend_vld_reg |-> (op_reg == kqrt_pkg::OP_SHIP),
                 "pending beat outside ship")
endmodule

// ----- hdl/kqrt_ctrl.sv -----
// Controller state machine sequencing scans, compaction, sort passes and ship.
// Depends on kqrt_pkg.
module kqrt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  kqrt_pkg::sts_t sts,
    output kqrt_pkg::cmd_t cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_INSERT, S_HELD, S_WB, S_REPLY,
        S_SHIFT_RD, S_SHIFT_WR, S_SORT_PASS, S_SORT_RD0, S_SORT_LD, S_SORT_RD,
        S_SORT_CMP, S_SHIP_RD, S_SHIP_CHK, S_SHIP_HIT, S_SHIP_FLUSH
    } state_t;

    state_t                    state_reg, state_next;
    logic [kqrt_pkg::ST_W-1:0] code_reg, code_next;
    logic                      rsel_reg, rsel_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        code_next  = code_reg;
        rsel_next  = rsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.opcode)
                    kqrt_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            code_next  = kqrt_pkg::ST_FULL;
                            rsel_next  = 1'b0;
                            state_next = S_REPLY;
                        end
                        else if (sts.range_bad)
                        begin
                            code_next  = kqrt_pkg::ST_BAD_AMT;
                            rsel_next  = 1'b0;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    kqrt_pkg::OP_LOOKUP, kqrt_pkg::OP_REMOVE,
                    kqrt_pkg::OP_ADD, kqrt_pkg::OP_REDUCE:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                    kqrt_pkg::OP_SORT:
                    begin
                        cmd.pass_clr = 1'b1;
                        state_next   = S_SORT_PASS;
                    end
                    kqrt_pkg::OP_SHIP:
                    begin
                        cmd.idx_clr  = 1'b1;
                        cmd.pend_clr = 1'b1;
                        state_next   = S_SHIP_RD;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            // key search: read one row, then check its key
            S_SCAN_RD:
            begin
                if (sts.idx_end)
                begin
                    if (sts.opcode == kqrt_pkg::OP_INSERT)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        code_next  = kqrt_pkg::ST_NOT_FOUND;
                        rsel_next  = 1'b0;
                        state_next = S_REPLY;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.hold_ld = 1'b1;
                    state_next  = S_HELD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_INSERT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wa_sel   = kqrt_pkg::WA_CNT;
                cmd.wd_sel   = kqrt_pkg::WD_NEW;
                cmd.hold_new = 1'b1;
                cmd.cnt_inc  = 1'b1;
                code_next    = kqrt_pkg::ST_OK;
                rsel_next    = 1'b1;
                state_next   = S_REPLY;
            end
            // record found: decide per opcode
            S_HELD:
            begin
                rsel_next  = 1'b1;
                state_next = S_REPLY;
                case (sts.opcode)
                    kqrt_pkg::OP_INSERT: code_next = kqrt_pkg::ST_DUP;
                    kqrt_pkg::OP_LOOKUP: code_next = kqrt_pkg::ST_OK;
                    kqrt_pkg::OP_REMOVE: code_next = kqrt_pkg::ST_OK;
                    kqrt_pkg::OP_ADD:
                    begin
                        if (sts.add_full)
                        begin
                            code_next = kqrt_pkg::ST_FULFILLED;
                        end
                        else if (sts.add_bad)
                        begin
                            code_next = kqrt_pkg::ST_BAD_AMT;
                        end
                        else
                        begin
                            cmd.have_upd = 1'b1;
                            state_next   = S_WB;
                        end
                    end
                    kqrt_pkg::OP_REDUCE:
                    begin
                        if (sts.red_zero)
                        begin
                            code_next = kqrt_pkg::ST_ZERO;
                        end
                        else if (sts.red_bad)
                        begin
                            code_next = kqrt_pkg::ST_BAD_AMT;
                        end
                        else
                        begin
                            cmd.have_upd = 1'b1;
                            state_next   = S_WB;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WB:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = kqrt_pkg::WA_ROW;
                cmd.wd_sel = kqrt_pkg::WD_HELD;
                code_next  = kqrt_pkg::ST_OK;
                state_next = S_REPLY;
            end
            // single result beat
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_src  = rsel_reg ? kqrt_pkg::OS_REC : kqrt_pkg::OS_NONE;
                    cmd.st       = code_reg;
                    cmd.out_last = 1'b1;
                    if ((sts.opcode == kqrt_pkg::OP_REMOVE) && (code_reg == kqrt_pkg::ST_OK))
                    begin
                        cmd.out_dec      = 1'b1;
                        cmd.idx_from_row = 1'b1;
                        state_next       = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            // compaction: move rows below the dropped one up by one
            S_SHIFT_RD:
            begin
                if (sts.idx1_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (sts.opcode == kqrt_pkg::OP_SHIP)
                    begin
                        cmd.idx_from_row = 1'b1;
                        state_next       = S_SHIP_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = kqrt_pkg::WA_IDX;
                cmd.wd_sel  = kqrt_pkg::WD_RD;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHIFT_RD;
            end
            // bubble passes carrying one record down the table
            S_SORT_PASS:
            begin
                if (sts.pass_end)
                begin
                    code_next  = kqrt_pkg::ST_OK;
                    rsel_next  = 1'b0;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SORT_RD0;
                end
            end
            S_SORT_RD0:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SORT_LD;
            end
            S_SORT_LD:
            begin
                cmd.hold_ld = 1'b1;
                state_next  = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                if (sts.idx1_end)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wa_sel   = kqrt_pkg::WA_IDX;
                    cmd.wd_sel   = kqrt_pkg::WD_HELD;
                    cmd.pass_inc = 1'b1;
                    state_next   = S_SORT_PASS;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = kqrt_pkg::WA_IDX;
                cmd.idx_inc = 1'b1;
                if (sts.swap)
                begin
                    cmd.wd_sel = kqrt_pkg::WD_RD;
                end
                else
                begin
                    cmd.wd_sel  = kqrt_pkg::WD_HELD;
                    cmd.hold_ld = 1'b1;
                end
                state_next = S_SORT_RD;
            end
            // ship: each match is held back one beat to know the final one
            S_SHIP_RD:
            begin
                if (sts.idx_end)
                begin
                    if (sts.pend_vld)
                    begin
                        state_next = S_SHIP_FLUSH;
                    end
                    else
                    begin
                        code_next  = kqrt_pkg::ST_NOTHING;
                        rsel_next  = 1'b0;
                        state_next = S_REPLY;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SHIP_CHK;
                end
            end
            S_SHIP_CHK:
            begin
                if (sts.ship_eq)
                begin
                    cmd.hold_ld = 1'b1;
                    state_next  = S_SHIP_HIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SHIP_RD;
                end
            end
            S_SHIP_HIT:
            begin
                if (!sts.pend_vld || sts.out_free)
                begin
                    if (sts.pend_vld)
                    begin
                        cmd.out_ld  = 1'b1;
                        cmd.out_src = kqrt_pkg::OS_PEND;
                        cmd.st      = kqrt_pkg::ST_OK;
                    end
                    cmd.pend_ld = 1'b1;
                    state_next  = S_SHIFT_RD;
                end
            end
            S_SHIP_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_src  = kqrt_pkg::OS_PEND;
                    cmd.st       = kqrt_pkg::ST_OK;
                    cmd.out_last = 1'b1;
                    cmd.pend_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= kqrt_pkg::ST_OK;
            rsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            rsel_reg  <= rsel_next;
        end
    end
endmodule

// ----- hdl/keyed_quantity_record_table.sv -----
// Top level of the keyed quantity record table: controller, datapath and channels.
// Depends on kqrt_pkg, kqrt_if, kqrt_ctrl and kqrt_dp.
//
//  channel  dir  fields                                              beats per command
//  req      in   opcode item_key have_init need_init amount          1
//  rsp      out  status row rec_key rec_have rec_need entries last   1, or 1 per shipped record
//
// One command at a time; the memory has one read and one write port. Lookup, remove,
// add, reduce and insert search the rows in turn; remove then moves each later row up
// by one. Sort runs bubble passes over the rows. Ship scans the rows and, for each
// shipped record, moves the later rows up. Reset clears the count and control state,
// not the rows; rows are never read above the count, so no clearing pass.
// A stalled result holds in the result register and the controller waits on it.
module keyed_quantity_record_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int QTY_BITS    = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    kqrt_req_if.sink   req,
    kqrt_rsp_if.source rsp
);
    kqrt_pkg::cmd_t cmd;
    kqrt_pkg::sts_t sts;

    kqrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kqrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .QTY_BITS    (QTY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (req.opcode),
        .item_key  (req.item_key),
        .have_init (req.have_init),
        .need_init (req.need_init),
        .amount    (req.amount),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (rsp.status),
        .row       (rsp.row),
        .rec_key   (rsp.rec_key),
        .rec_have  (rsp.rec_have),
        .rec_need  (rsp.rec_need),
        .entries   (rsp.entries),
        .last      (rsp.last)
    );
endmodule

// ----- verif/keyed_quantity_record_table_tb.sv -----
// Self-checking testbench for the keyed quantity record table.
// Depends on kqrt_pkg, kqrt_if and keyed_quantity_record_table from the RTL.
`timescale 1ns / 1ps
module keyed_quantity_record_table_tb;

    localparam int DEPTH      = 64;
    localparam int QBITS      = 14;
    localparam int CYCLE_CAP  = 20000000;
    localparam logic [kqrt_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [kqrt_pkg::ST_W-1:0]  status;
        logic [5:0]                 row;
        logic [kqrt_pkg::KEY_W-1:0] rec_key;
        logic [QBITS-1:0]           rec_have;
        logic [QBITS-1:0]           rec_need;
        logic [6:0]                 entries;
        logic                       last;
    } result_t;

    logic clk;
    logic rst_n;

    kqrt_req_if #(.QTY_BITS(QBITS)) req_ch();
    kqrt_rsp_if #(.QTY_BITS(QBITS)) rsp_ch();

    keyed_quantity_record_table #(.TABLE_DEPTH(DEPTH), .QTY_BITS(QBITS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the table
    logic [kqrt_pkg::KEY_W-1:0] tbl_key  [DEPTH];
    logic [QBITS-1:0]           tbl_have [DEPTH];
    logic [QBITS-1:0]           tbl_need [DEPTH];
    int                         tbl_cnt;

    result_t expected_q[$];
    int      mismatches;
    bit      send_idle;
    bit      recv_idle;
    bit      long_hold;
    int      cycles;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic result_t record_view(logic [kqrt_pkg::ST_W-1:0] st, int r, bit lst);
        result_t res;
        res = '0;
        res.status = st;
        if (r >= 0)
        begin
            res.row      = r[5:0];
            res.rec_key  = tbl_key[r];
            res.rec_have = tbl_have[r];
            res.rec_need = tbl_need[r];
        end
        res.entries = tbl_cnt[6:0];
        res.last    = lst;
        return res;
    endfunction

    function automatic int find_key(logic [kqrt_pkg::KEY_W-1:0] k);
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int r);
        for (int i = r; i + 1 < tbl_cnt; i++)
        begin
            tbl_key[i]  = tbl_key[i+1];
            tbl_have[i] = tbl_have[i+1];
            tbl_need[i] = tbl_need[i+1];
        end
        tbl_cnt--;
    endfunction

    function automatic int shortfall_of(int r);
        return int'(tbl_need[r]) - int'(tbl_have[r]);
    endfunction

    // apply one accepted command to the shadow table and queue its results
    function automatic void table_update(logic [kqrt_pkg::OP_W-1:0] op,
                                         logic [kqrt_pkg::KEY_W-1:0] k,
                                         logic [QBITS-1:0] h, logic [QBITS-1:0] n,
                                         logic [QBITS-1:0] amt);
        int      r;
        int      shipped;
        result_t res;
        logic [kqrt_pkg::KEY_W-1:0] tk;
        logic [QBITS-1:0] th, tn;
        case (op)
            kqrt_pkg::OP_INSERT:
            begin
                if (tbl_cnt >= DEPTH)
                    expected_q.push_back(record_view(kqrt_pkg::ST_FULL, -1, 1'b1));
                else if (k < kqrt_pkg::KEY_LOW || k > kqrt_pkg::KEY_HIGH
                         || h > 9999 || n > 9999)
                    expected_q.push_back(record_view(kqrt_pkg::ST_BAD_AMT, -1, 1'b1));
                else
                begin
                    r = find_key(k);
                    if (r >= 0)
                        expected_q.push_back(record_view(kqrt_pkg::ST_DUP, r, 1'b1));
                    else
                    begin
                        tbl_key[tbl_cnt]  = k;
                        tbl_have[tbl_cnt] = h;
                        tbl_need[tbl_cnt] = n;
                        tbl_cnt++;
                        expected_q.push_back(record_view(kqrt_pkg::ST_OK, tbl_cnt - 1, 1'b1));
                    end
                end
            end
            kqrt_pkg::OP_LOOKUP, kqrt_pkg::OP_REMOVE, kqrt_pkg::OP_ADD, kqrt_pkg::OP_REDUCE:
            begin
                r = find_key(k);
                if (r < 0)
                    expected_q.push_back(record_view(kqrt_pkg::ST_NOT_FOUND, -1, 1'b1));
                else if (op == kqrt_pkg::OP_LOOKUP)
                    expected_q.push_back(record_view(kqrt_pkg::ST_OK, r, 1'b1));
                else if (op == kqrt_pkg::OP_REMOVE)
                begin
                    res = record_view(kqrt_pkg::ST_OK, r, 1'b1);
                    drop_entry(r);
                    res.entries = tbl_cnt[6:0];
                    expected_q.push_back(res);
                end
                else if (op == kqrt_pkg::OP_ADD)
                begin
                    if (tbl_have[r] >= tbl_need[r])
                        expected_q.push_back(record_view(kqrt_pkg::ST_FULFILLED, r, 1'b1));
                    else if (amt == 0 || amt > tbl_need[r] - tbl_have[r])
                        expected_q.push_back(record_view(kqrt_pkg::ST_BAD_AMT, r, 1'b1));
                    else
                    begin
                        tbl_have[r] = tbl_have[r] + amt;
                        expected_q.push_back(record_view(kqrt_pkg::ST_OK, r, 1'b1));
                    end
                end
                else
                begin
                    if (tbl_have[r] == 0)
                        expected_q.push_back(record_view(kqrt_pkg::ST_ZERO, r, 1'b1));
                    else if (amt == 0 || amt > tbl_have[r])
                        expected_q.push_back(record_view(kqrt_pkg::ST_BAD_AMT, r, 1'b1));
                    else
                    begin
                        tbl_have[r] = tbl_have[r] - amt;
                        expected_q.push_back(record_view(kqrt_pkg::ST_OK, r, 1'b1));
                    end
                end
            end
            kqrt_pkg::OP_SORT:
            begin
                // stable bubble sort, largest shortfall first
                for (int i = 0; i < tbl_cnt; i++)
                    for (int j = 0; j + 1 < tbl_cnt; j++)
                        if (shortfall_of(j) < shortfall_of(j + 1))
                        begin
                            tk = tbl_key[j];  th = tbl_have[j];  tn = tbl_need[j];
                            tbl_key[j]  = tbl_key[j+1];
                            tbl_have[j] = tbl_have[j+1];
                            tbl_need[j] = tbl_need[j+1];
                            tbl_key[j+1] = tk;  tbl_have[j+1] = th;  tbl_need[j+1] = tn;
                        end
                expected_q.push_back(record_view(kqrt_pkg::ST_OK, -1, 1'b1));
            end
            kqrt_pkg::OP_SHIP:
            begin
                shipped = 0;
                r = 0;
                while (r < tbl_cnt)
                begin
                    if (tbl_have[r] == tbl_need[r])
                    begin
                        res = record_view(kqrt_pkg::ST_OK, r, 1'b0);
                        drop_entry(r);
                        res.entries = tbl_cnt[6:0];
                        expected_q.push_back(res);
                        shipped++;
                    end
                    else
                        r++;
                end
                if (shipped == 0)
                    expected_q.push_back(record_view(kqrt_pkg::ST_NOTHING, -1, 1'b1));
                else
                    expected_q[$].last = 1'b1;
            end
            default: ;  // unused opcode: no result
        endcase
    endfunction

    // result receiver with random stalls and an optional long hold-off
    int stall_left;
    always @(posedge clk)
    begin
        if (long_hold && stall_left == 0)
        begin
            long_hold  <= 1'b0;
            stall_left <= 400;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end
        else if (recv_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.status, rsp_ch.row, rsp_ch.rec_key, rsp_ch.rec_have,
                    rsp_ch.rec_need, rsp_ch.entries, rsp_ch.last};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // offer one command and hold it until accepted
    task automatic send_cmd(logic [kqrt_pkg::OP_W-1:0] op, logic [kqrt_pkg::KEY_W-1:0] k,
                            logic [QBITS-1:0] h, logic [QBITS-1:0] n,
                            logic [QBITS-1:0] amt);
        int gap;
        gap = (send_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.item_key  <= k;
        req_ch.have_init <= h;
        req_ch.need_init <= n;
        req_ch.amount    <= amt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        table_update(op, k, h, n, amt);
    endtask

    function automatic logic [kqrt_pkg::KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60 && tbl_cnt > 0)
            return tbl_key[$urandom_range(0, tbl_cnt - 1)];
        if (sel < 92)
            return kqrt_pkg::KEY_LOW + kqrt_pkg::KEY_W'($urandom_range(0, 90));
        if (sel < 96)
            return kqrt_pkg::KEY_HIGH;
        return kqrt_pkg::KEY_W'($urandom_range(0, 131071));
    endfunction

    function automatic logic [QBITS-1:0] pick_qty();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return QBITS'($urandom_range(0, 20));
        if (sel < 9)
            return QBITS'($urandom_range(0, 9999));
        return QBITS'($urandom_range(0, 16383));
    endfunction

    // one random command, biased toward the table's current contents
    task automatic random_cmd();
        int sel, r;
        logic [kqrt_pkg::KEY_W-1:0] k;
        logic [QBITS-1:0] h, n, amt;
        sel = $urandom_range(0, 99);
        k   = pick_key();
        h   = pick_qty();
        n   = ($urandom_range(0, 2) == 0) ? h : pick_qty();
        amt = pick_qty();
        r   = find_key(k);
        if (r >= 0 && $urandom_range(0, 1) == 0)
        begin
            if (sel >= 57 && sel < 72 && tbl_need[r] > tbl_have[r])
                amt = tbl_need[r] - tbl_have[r];
            else if (sel >= 72 && sel < 85 && tbl_have[r] > tbl_need[r])
                amt = tbl_have[r] - tbl_need[r];
            else if (sel >= 72 && sel < 85)
                amt = tbl_have[r];
        end
        if (sel < 35)       send_cmd(kqrt_pkg::OP_INSERT, k, h, n, amt);
        else if (sel < 45)  send_cmd(kqrt_pkg::OP_LOOKUP, k, h, n, amt);
        else if (sel < 57)  send_cmd(kqrt_pkg::OP_REMOVE, k, h, n, amt);
        else if (sel < 72)  send_cmd(kqrt_pkg::OP_ADD, k, h, n, amt);
        else if (sel < 85)  send_cmd(kqrt_pkg::OP_REDUCE, k, h, n, amt);
        else if (sel < 89)  send_cmd(kqrt_pkg::OP_SORT, k, h, n, amt);
        else if (sel < 98)  send_cmd(kqrt_pkg::OP_SHIP, k, h, n, amt);
        else                send_cmd(OP_UNUSED, k, h, n, amt);
    endtask

    // edge values, every opcode and every status except table full
    task automatic test_directed();
        send_cmd(kqrt_pkg::OP_SHIP,   17'd0,     '0, '0, '0);
        send_cmd(kqrt_pkg::OP_SORT,   17'd0,     '0, '0, '0);
        send_cmd(kqrt_pkg::OP_INSERT, kqrt_pkg::KEY_LOW,   14'd0, 14'd9999, '0);
        send_cmd(kqrt_pkg::OP_INSERT, kqrt_pkg::KEY_HIGH,  14'd9999, 14'd0, '0);
        send_cmd(kqrt_pkg::OP_INSERT, 17'd50000, 14'd5, 14'd5, '0);
        send_cmd(kqrt_pkg::OP_INSERT, 17'd9999,  14'd1, 14'd2, '0);
        send_cmd(kqrt_pkg::OP_INSERT, 17'd100000, 14'd1, 14'd2, '0);
        send_cmd(kqrt_pkg::OP_INSERT, 17'h1FFFF, 14'h3FFF, 14'h3FFF, '0);
        send_cmd(kqrt_pkg::OP_INSERT, 17'd20000, 14'd10000, 14'd1, '0);
        send_cmd(kqrt_pkg::OP_INSERT, kqrt_pkg::KEY_LOW,   14'd3, 14'd3, '0);
        send_cmd(kqrt_pkg::OP_LOOKUP, kqrt_pkg::KEY_HIGH,  '0, '0, '0);
        send_cmd(kqrt_pkg::OP_LOOKUP, 17'd12345, '0, '0, '0);
        send_cmd(kqrt_pkg::OP_ADD,    kqrt_pkg::KEY_HIGH,  '0, '0, 14'd1);
        send_cmd(kqrt_pkg::OP_ADD,    kqrt_pkg::KEY_LOW,   '0, '0, 14'd0);
        send_cmd(kqrt_pkg::OP_ADD,    kqrt_pkg::KEY_LOW,   '0, '0, 14'd10000);
        send_cmd(kqrt_pkg::OP_ADD,    kqrt_pkg::KEY_LOW,   '0, '0, 14'd9998);
        send_cmd(kqrt_pkg::OP_REDUCE, 17'd10000, '0, '0, 14'h3FFF);
        send_cmd(kqrt_pkg::OP_REDUCE, kqrt_pkg::KEY_HIGH,  '0, '0, 14'd9999);
        send_cmd(kqrt_pkg::OP_REDUCE, kqrt_pkg::KEY_HIGH,  '0, '0, 14'd1);
        send_cmd(kqrt_pkg::OP_INSERT, 17'd60000, 14'd7, 14'd2, '0);
        send_cmd(kqrt_pkg::OP_SORT,   17'd0,     '0, '0, '0);
        send_cmd(OP_UNUSED,           17'd0,     '0, '0, '0);
        send_cmd(kqrt_pkg::OP_REMOVE, 17'd50000, '0, '0, '0);
        send_cmd(kqrt_pkg::OP_REMOVE, 17'd50000, '0, '0, '0);
        send_cmd(kqrt_pkg::OP_ADD,    kqrt_pkg::KEY_LOW,   '0, '0, 14'd1);
        send_cmd(kqrt_pkg::OP_SHIP,   17'd0,     '0, '0, '0);
    endtask

    // fill the table to the top, overflow it, sort and ship in bulk
    task automatic test_full_table();
        logic [QBITS-1:0] h;
        int tries;
        tries = 0;
        while (tbl_cnt < DEPTH && tries < 200)
        begin
            h = QBITS'($urandom_range(0, 9999));
            send_cmd(kqrt_pkg::OP_INSERT,
                     17'd30000 + kqrt_pkg::KEY_W'($urandom_range(0, 999)), h,
                     $urandom_range(0, 1) ? h : 14'($urandom_range(0, 9999)), '0);
            tries++;
        end
        send_cmd(kqrt_pkg::OP_INSERT, 17'd99000, 14'd1, 14'd1, '0);
        send_cmd(kqrt_pkg::OP_SORT,   17'd0, '0, '0, '0);
        send_cmd(kqrt_pkg::OP_SHIP,   17'd0, '0, '0, '0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            random_cmd();
    endtask

    // hold off the receiver while commands keep coming
    task automatic test_backpressure();
        send_idle = 1'b0;
        long_hold <= 1'b1;
        for (int i = 0; i < 20; i++)
            random_cmd();
        send_idle = 1'b1;
    endtask

    initial
    begin
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= '0;
        req_ch.item_key  <= '0;
        req_ch.have_init <= '0;
        req_ch.need_init <= '0;
        req_ch.amount    <= '0;
        rst_n      <= 1'b0;
        tbl_cnt    = 0;
        mismatches = 0;
        cycles     = 0;
        stall_left = 0;
        long_hold  = 1'b0;
        send_idle  = 1'b1;
        recv_idle  = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random(160);
        test_backpressure();
        test_random(160);
        // closing stretch runs with no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        test_random(60);
        req_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
